/* rtl/adc_reading_text_formatter_defines.svh */
// assertion macros for the adc reading text formatter
`ifndef ADC_READING_TEXT_FORMATTER_DEFINES_SVH
`define ADC_READING_TEXT_FORMATTER_DEFINES_SVH
`ifndef SYNTHESIS
`define ADC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ADC_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> prop) else $error(msg);
`else
`define ADC_ASSERT(name, prop, msg)
`define ADC_ASSERT_NEXT(name, cond, prop, msg)
`endif
`endif

/* rtl/adc_txt_pkg.sv */
// package with constants, text tables and helpers of the adc reading text formatter
`timescale 1ns / 1ps
package adc_txt_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int THRESH_W        = 12;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd970;
  localparam int SCALE_W         = 16;
  localparam logic [SCALE_W-1:0] SCALE_MV = 16'd33000;
  localparam int VALUE_W         = 16;
  localparam int STEP_W          = 17;
  localparam int IDX_W           = 4;
  localparam int POS_W           = 3;

  localparam logic [IDX_W-1:0] IDX_POINT      = 4'd3;
  localparam logic [IDX_W-1:0] IDX_TAIL       = 4'd6;
  localparam logic [IDX_W-1:0] IDX_ALERT_LAST = 4'd6;
  localparam logic [IDX_W-1:0] IDX_LINE_LAST  = 4'd12;

  localparam logic [POS_W-1:0] POS_TEN_K    = 3'd0;
  localparam logic [POS_W-1:0] POS_THOUSAND = 3'd1;
  localparam logic [POS_W-1:0] POS_HUNDRED  = 3'd2;
  localparam logic [POS_W-1:0] POS_TEN      = 3'd3;
  localparam logic [POS_W-1:0] POS_ONE      = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [7:0] ALERT_TEXT [7] = '{8'h41, 8'h4C, 8'h45, 8'h52, 8'h54, 8'h0D, 8'h0A};
  localparam logic [7:0] TAIL_TEXT  [7] = '{8'h20, 8'h20, 8'h2A, 8'h20, 8'h43, 8'h0D, 8'h0A};

  typedef struct packed {
    logic               alert;
    logic [VALUE_W-1:0] rem;
    logic [IDX_W-1:0]   idx;
  } line_t;

  // m times the decimal weight of a digit place
  function automatic logic [STEP_W-1:0] step_value(input logic [POS_W-1:0] pos, input int m);
    logic [STEP_W-1:0] res;
    case (pos)
      POS_TEN_K:    res = STEP_W'(m * 10000);
      POS_THOUSAND: res = STEP_W'(m * 1000);
      POS_HUNDRED:  res = STEP_W'(m * 100);
      POS_TEN:      res = STEP_W'(m * 10);
      POS_ONE:      res = STEP_W'(m);
      default:      res = '1;
    endcase
    return res;
  endfunction

endpackage

/* rtl/adc_reading_text_formatter.sv */
// adc reading text formatter top level
// Usage:
//   input channel (in_valid_i / in_ready_o / sample_i) takes one raw converter
//   sample per request. Output channel (out_valid_o / out_ready_i) gives one
//   ASCII character per request with last_byte_o, fan_on_o and alert_o.
//   A sample below the alert threshold gives 13 characters "ddd.dd  * C" CR LF
//   with value = floor(33000 * sample / 2^SAMPLE_BITS); a sample at or above
//   it gives "ALERT" CR LF with fan_on_o and alert_o set.
//   The threshold is written over cfg_valid_i / cfg_ready_o / alert_threshold_i;
//   cfg_ready_o is always high.
// Timing:
//   the first character of a line is offered once the sample has passed the
//   input register, scaling multiplier register, line state register and character
//   register. A line then gives one character per cycle while out_ready_i is
//   high, and the next line follows with no gap; the single output port sets
//   the rate of samples for readings. Two samples can wait in the input and
//   scaling registers while a line is sent.
// Reset and stall:
//   reset empties all stages and sets the threshold to 970. While out_ready_i
//   is low the character register holds and the stages behind it fill, then
//   in_ready_o drops; nothing is lost.
`timescale 1ns / 1ps
`include "adc_reading_text_formatter_defines.svh"
module adc_reading_text_formatter #(
  parameter int SAMPLE_BITS = adc_txt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SAMPLE_BITS-1:0]           sample_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [adc_txt_pkg::THRESH_W-1:0] alert_threshold_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       text_byte_o,
  output logic                             last_byte_o,
  output logic                             fan_on_o,
  output logic                             alert_o
);
  import adc_txt_pkg::*;

  localparam int CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam int PROD_W = SCALE_W + SAMPLE_BITS;

  logic [THRESH_W-1:0]    thresh_q;
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s2_valid_q;
  logic [VALUE_W-1:0]     s2_value_q;
  logic                   s2_alert_q;
  logic                   ser_active_q;
  line_t                  ser_q, ser_d;
  logic                   out_valid_q;
  logic [7:0]             text_byte_q, text_byte_d;
  logic                   last_byte_q, alert_q;

  logic [PROD_W-1:0]      prod;
  logic                   s1_alert;
  logic                   out_adv, emit, ser_last, ser_load, s2_free, s1_move;
  logic                   is_digit;
  logic [POS_W-1:0]       pos;
  logic [3:0]             digit;
  logic [STEP_W-1:0]      sub;

  assign cfg_ready_o = 1'b1;

  // scaling and threshold compare
  assign prod     = PROD_W'(SCALE_MV) * PROD_W'(s1_sample_q);
  assign s1_alert = CMP_W'(s1_sample_q) >= CMP_W'(thresh_q);

  // stage handshakes
  assign out_adv    = !out_valid_q || out_ready_i;
  assign emit       = ser_active_q && out_adv;
  assign ser_last   = ser_q.alert ? (ser_q.idx == IDX_ALERT_LAST) : (ser_q.idx == IDX_LINE_LAST);
  assign ser_load   = s2_valid_q && (!ser_active_q || (emit && ser_last));
  assign s2_free    = !s2_valid_q || ser_load;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;

  // digit place of the current character
  always_comb begin
    is_digit = 1'b1;
    pos      = POS_TEN_K;
    case (ser_q.idx)
      4'd0:    pos = POS_TEN_K;
      4'd1:    pos = POS_THOUSAND;
      4'd2:    pos = POS_HUNDRED;
      4'd4:    pos = POS_TEN;
      4'd5:    pos = POS_ONE;
      default: is_digit = 1'b0;
    endcase
  end

  // one decimal digit by a bank of compares
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int m = 1; m < 10; m++) begin
      if (STEP_W'(ser_q.rem) >= step_value(pos, m)) begin
        digit = 4'(m);
        sub   = step_value(pos, m);
      end
    end
  end

  // character select
  always_comb begin
    if (ser_q.alert) begin
      text_byte_d = ALERT_TEXT[ser_q.idx[2:0]];
    end else if (is_digit) begin
      text_byte_d = CH_ZERO + 8'(digit);
    end else if (ser_q.idx == IDX_POINT) begin
      text_byte_d = CH_POINT;
    end else begin
      text_byte_d = TAIL_TEXT[3'(ser_q.idx - IDX_TAIL)];
    end
  end

  // next line state
  always_comb begin
    ser_d = ser_q;
    if (ser_load) begin
      ser_d.alert = s2_alert_q;
      ser_d.rem   = s2_value_q;
      ser_d.idx   = '0;
    end else if (emit) begin
      ser_d.idx = ser_q.idx + 4'd1;
      if (is_digit && !ser_q.alert) begin
        ser_d.rem = ser_q.rem - VALUE_W'(sub);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q     <= THRESH_RESET;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      ser_active_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thresh_q <= alert_threshold_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (ser_load) begin
        ser_active_q <= 1'b1;
      end else if (emit && ser_last) begin
        ser_active_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= ser_active_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= sample_i;
    end
    if (s1_move) begin
      s2_value_q <= prod[SAMPLE_BITS +: VALUE_W];
      s2_alert_q <= s1_alert;
    end
    ser_q <= ser_d;
    if (emit) begin
      text_byte_q <= text_byte_d;
      last_byte_q <= ser_last;
      alert_q     <= ser_q.alert;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_byte_o = text_byte_q;
  assign last_byte_o = last_byte_q;
  assign fan_on_o    = alert_q;
  assign alert_o     = alert_q;

  `ADC_ASSERT(a_alert_idx, ser_active_q && ser_q.alert |-> ser_q.idx <= IDX_ALERT_LAST, "alert line past its end")
  `ADC_ASSERT(a_last_is_lf, out_valid_q && last_byte_q |-> text_byte_q == CH_LF, "last character is not LF")
  `ADC_ASSERT_NEXT(a_load_starts, s2_valid_q && !ser_active_q, ser_active_q && ser_q.idx == '0, "waiting line not started")
  `ADC_ASSERT(a_digit_range, ser_active_q && !ser_q.alert && is_digit |-> STEP_W'(ser_q.rem) < step_value(pos, 10), "remainder exceeds digit place")

endmodule

/* sim/tb.sv */
// testbench for the adc reading text formatter, random requests checked against a line predictor
`timescale 1ns / 1ps
module tb;
  import adc_txt_pkg::*;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          STALL_CYCLES = 120;
  localparam int          IDLE_PCT     = 29;
  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam string       TAIL_WORD    = "  * C";
  localparam string       ALERT_WORD   = "ALERT";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fan;
    logic       alarm;
  } char_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [11:0]         sample_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [THRESH_W-1:0] alert_threshold_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          text_byte_o;
  logic                last_byte_o;
  logic                fan_on_o;
  logic                alert_o;

  logic [11:0]         pending_samples[$];
  char_t               line_chars[$];
  char_t               want;
  logic [THRESH_W-1:0] thresh_now = THRESH_RESET;
  logic                sample_taken = 1'b0;
  int                  n_offered = 0;
  int                  n_taken = 0;
  int                  mismatches = 0;
  int                  cycles = 0;
  int                  idle_pct = IDLE_PCT;
  int                  hold_left = 0;
  bit                  stall_req = 1'b0;

  adc_reading_text_formatter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .alert_threshold_i (alert_threshold_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .text_byte_o       (text_byte_o),
    .last_byte_o       (last_byte_o),
    .fan_on_o          (fan_on_o),
    .alert_o           (alert_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected characters of the line for one sample
  task automatic format_reading(input logic [11:0] s);
    logic [27:0] prod;
    int          value;
    logic [7:0]  line[$];
    bit          alarm;
    alarm = (s >= thresh_now);
    if (alarm) begin
      for (int k = 0; k < ALERT_WORD.len(); k++) line.push_back(ALERT_WORD[k]);
    end else begin
      prod  = 28'(s) * 28'd33000;
      value = int'(prod >> 12);
      line.push_back(8'(CH_ZERO + (value / 10000) % 10));
      line.push_back(8'(CH_ZERO + (value / 1000) % 10));
      line.push_back(8'(CH_ZERO + (value / 100) % 10));
      line.push_back(CH_POINT);
      line.push_back(8'(CH_ZERO + (value / 10) % 10));
      line.push_back(8'(CH_ZERO + value % 10));
      for (int k = 0; k < TAIL_WORD.len(); k++) line.push_back(TAIL_WORD[k]);
    end
    line.push_back(CH_CR);
    line.push_back(CH_LF);
    for (int k = 0; k < line.size(); k++)
      line_chars.push_back('{ch: line[k], last: (k == line.size() - 1), fan: alarm,
                             alarm: alarm});
  endtask

  function automatic logic [11:0] pick_sample();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(4095));
      1: v = int'(thresh_now) - 2 + int'($urandom_range(3));
      default: v = (thresh_now == 0) ? 0 : int'($urandom_range(int'(thresh_now) - 1));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  task automatic offer(input logic [11:0] s);
    pending_samples.push_back(s);
    n_offered++;
  endtask

  task automatic offer_random(input int n);
    repeat (n) offer(pick_sample());
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || n_taken != n_offered || line_chars.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    alert_threshold_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    thresh_now = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sample driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || sample_taken) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        sample_i   <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // character receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_req) begin
      stall_req = 1'b0;
      hold_left = STALL_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        format_reading(sample_i);
        n_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (line_chars.size() == 0) begin
          $display("%0t unexpected character: expected none, actual %h", $time, text_byte_o);
          mismatches++;
        end else begin
          want = line_chars.pop_front();
          if (text_byte_o !== want.ch) begin
            $display("%0t text_byte: expected %h, actual %h", $time, want.ch, text_byte_o);
            mismatches++;
          end
          if (last_byte_o !== want.last) begin
            $display("%0t last_byte: expected %b, actual %b", $time, want.last, last_byte_o);
            mismatches++;
          end
          if (fan_on_o !== want.fan) begin
            $display("%0t fan_on: expected %b, actual %b", $time, want.fan, fan_on_o);
            mismatches++;
          end
          if (alert_o !== want.alarm) begin
            $display("%0t alert: expected %b, actual %b", $time, want.alarm, alert_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("adc_reading_text_formatter: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset threshold, edges around it
    offer(12'd0);    offer(12'd1);    offer(12'd2);    offer(12'd124);
    offer(12'd500);  offer(12'd683);  offer(12'd968);  offer(12'd969);
    offer(12'd970);  offer(12'd971);  offer(12'd2730); offer(12'd4095);
    drain();

    write_threshold(12'd4095);
    offer(12'd4094); offer(12'd4095); offer(12'd2048);
    offer(12'd3000); offer(12'h555);  offer(12'hAAA);
    drain();

    // zero threshold, every sample alerts
    write_threshold(12'd0);
    offer(12'd0); offer(12'd4095); offer(12'd1);
    drain();

    write_threshold(12'd2048);
    offer_random(30);
    drain();

    idle_pct = 0;
    write_threshold(12'($urandom_range(4095)));
    offer_random(20);
    drain();

    // long receiver hold-off so the pipeline backs up
    write_threshold(THRESH_RESET);
    stall_req = 1'b1;
    offer_random(20);
    drain();

    idle_pct = IDLE_PCT;
    write_threshold(12'd4095);
    offer_random(20);
    drain();

    if (mismatches == 0 && line_chars.size() == 0) begin
      $display("adc_reading_text_formatter: match");
    end else begin
      $display("adc_reading_text_formatter: mismatch");
    end
    $finish;
  end

endmodule
